[hw/rtl/sasm_pkg.sv]
// shared constants, types and the glyph table for the scaled adc display
// no dependencies; used by every module of the block
package sasm_pkg;

    localparam int ADC_BITS_DEFAULT = 10;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W = 8;
    localparam int TICKS_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_TICKS = 2'd1;

    // scaling codes in show_mode bits 1:0
    localparam logic [1:0] SCALE_X1   = 2'd0;
    localparam logic [1:0] SCALE_X2   = 2'd1;
    localparam logic [1:0] SCALE_X4   = 2'd2;
    localparam logic [1:0] SCALE_FULL = 2'd3;

    // digit positions on digit_select
    localparam logic [1:0] DIGIT_THOUSANDS = 2'd0;
    localparam logic [1:0] DIGIT_HUNDREDS  = 2'd1;
    localparam logic [1:0] DIGIT_TENS      = 2'd2;
    localparam logic [1:0] DIGIT_ONES      = 2'd3;

    // x5000/1024 full scale
    localparam int SCALE_NUM   = 5000;
    localparam int SCALE_SHIFT = 10;

    // reciprocal constants, exact for values below 2^15
    localparam int DIV5_MUL      = 52429;
    localparam int DIV5_SHIFT    = 18;
    localparam int DIV10_MUL     = 52429;
    localparam int DIV10_SHIFT   = 19;
    localparam int DIV100_MUL    = 5243;
    localparam int DIV100_SHIFT  = 19;
    localparam int DIV1000_MUL   = 67109;
    localparam int DIV1000_SHIFT = 26;

    localparam logic [4:0] GLYPH_BLANK = 5'd17;

    typedef struct packed {
        logic [3:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } digit_set_t;

    // segment patterns, bit0 segment a .. bit6 segment g
    function automatic logic [6:0] glyph_pattern(input logic [4:0] idx);
        logic [6:0] pat;
        case (idx)
            5'd0:  pat = 7'h3F;
            5'd1:  pat = 7'h06;
            5'd2:  pat = 7'h5B;
            5'd3:  pat = 7'h4F;
            5'd4:  pat = 7'h66;
            5'd5:  pat = 7'h6D;
            5'd6:  pat = 7'h7D;
            5'd7:  pat = 7'h07;
            5'd8:  pat = 7'h7F;
            5'd9:  pat = 7'h6F;
            5'd10: pat = 7'h40;
            5'd11: pat = 7'h00;
            5'd12: pat = 7'h76;
            5'd13: pat = 7'h76;
            5'd14: pat = 7'h76;
            5'd15: pat = 7'h76;
            5'd16: pat = 7'h40;
            5'd17: pat = 7'h00;
            5'd18: pat = 7'h00;
            5'd19: pat = 7'h76;
            5'd20: pat = 7'h76;
            default: pat = 7'h00;
        endcase
        return pat;
    endfunction

endpackage

[hw/rtl/sasm_scale.sv]
// sample scaling (x1, x2, x4, x5000/1024) and optional round to a multiple of five
// depends on sasm_pkg
module sasm_scale #(
    parameter int ADC_BITS = sasm_pkg::ADC_BITS_DEFAULT
) (
    input  logic [ADC_BITS-1:0] sample,
    input  logic [1:0]          scale_sel,
    input  logic                round_en,
    output logic [ADC_BITS+2:0] value
);

    localparam int VW = ADC_BITS + 3;
    localparam int PW = ADC_BITS + 13;
    localparam int DW = VW + 16;

    logic [PW-1:0] full_prod;
    logic [VW-1:0] base;
    logic [DW-1:0] div5_prod;
    logic [DW-1:0] div5_shifted;
    logic [VW-1:0] q5;
    logic [VW-1:0] rem_full;
    logic [2:0]    rem5;

    assign full_prod = PW'(sample) * PW'(sasm_pkg::SCALE_NUM);

    always_comb
    begin
        case (scale_sel)
            sasm_pkg::SCALE_X1: base = VW'(sample);
            sasm_pkg::SCALE_X2: base = VW'({sample, 1'b0});
            sasm_pkg::SCALE_X4: base = VW'({sample, 2'b00});
            default:            base = VW'(full_prod >> sasm_pkg::SCALE_SHIFT);
        endcase
    end

    // remainder mod 5 through a reciprocal multiply
    assign div5_prod    = DW'(base) * DW'(sasm_pkg::DIV5_MUL);
    assign div5_shifted = div5_prod >> sasm_pkg::DIV5_SHIFT;
    assign q5           = div5_shifted[VW-1:0];
    assign rem_full     = base - ((q5 << 2) + q5);
    assign rem5         = rem_full[2:0];

    always_comb
    begin
        value = base;
        if (round_en)
        begin
            case (rem5)
                3'd1:    value = base - VW'(1);
                3'd2:    value = base - VW'(2);
                3'd3:    value = base + VW'(2);
                3'd4:    value = base + VW'(1);
                default: value = base;
            endcase
        end
    end

endmodule

[hw/rtl/sasm_digits.sv]
// binary to four decimal digits, each power of ten through its own reciprocal multiply
// depends on sasm_pkg
module sasm_digits #(
    parameter int VALUE_W = sasm_pkg::ADC_BITS_DEFAULT + 3
) (
    input  logic [VALUE_W-1:0]   value,
    output sasm_pkg::digit_set_t digits
);

    localparam int MW = VALUE_W + 17;

    logic [MW-1:0]      p10;
    logic [MW-1:0]      p100;
    logic [MW-1:0]      p1000;
    logic [MW-1:0]      s10;
    logic [MW-1:0]      s100;
    logic [MW-1:0]      s1000;
    logic [VALUE_W-1:0] q10;
    logic [VALUE_W-1:0] q100;
    logic [VALUE_W-1:0] q1000;
    logic [VALUE_W-1:0] ones_full;
    logic [VALUE_W-1:0] tens_full;
    logic [VALUE_W-1:0] hund_full;
    logic [VALUE_W-1:0] thou_full;

    assign p10   = MW'(value) * MW'(sasm_pkg::DIV10_MUL);
    assign p100  = MW'(value) * MW'(sasm_pkg::DIV100_MUL);
    assign p1000 = MW'(value) * MW'(sasm_pkg::DIV1000_MUL);
    assign s10   = p10 >> sasm_pkg::DIV10_SHIFT;
    assign s100  = p100 >> sasm_pkg::DIV100_SHIFT;
    assign s1000 = p1000 >> sasm_pkg::DIV1000_SHIFT;
    assign q10   = s10[VALUE_W-1:0];
    assign q100  = s100[VALUE_W-1:0];
    assign q1000 = s1000[VALUE_W-1:0];

    // each digit is the quotient minus ten times the next quotient
    assign ones_full = value - ((q10 << 3) + (q10 << 1));
    assign tens_full = q10 - ((q100 << 3) + (q100 << 1));
    assign hund_full = q100 - ((q1000 << 3) + (q1000 << 1));
    // thousands stays below twenty, so one subtract wraps it
    assign thou_full = (q1000 >= VALUE_W'(10)) ? (q1000 - VALUE_W'(10)) : q1000;

    assign digits.ones      = ones_full[3:0];
    assign digits.tens      = tens_full[3:0];
    assign digits.hundreds  = hund_full[3:0];
    assign digits.thousands = thou_full[3:0];

endmodule

[hw/rtl/scaled_adc_seven_segment_mux_top.sv]
// Four-digit multiplexed seven-segment driver for a scaled converter sample. Each request
// carries a sample and a digit index and yields one result: segment pattern, one-hot
// digit enable and two decimal point drives. One request is accepted every clock cycle
// unless the pipeline is stalled; a result passes through the input register, scaled
// value register and result register, and the pipeline holds its place while out_ready
// is low. Writing either register restarts the mode display countdown, during which
// the mode code is shown on the middle digits. The configuration port is always ready.
// depends on sasm_pkg, sasm_scale, sasm_digits
module scaled_adc_seven_segment_mux_top #(
    parameter int ADC_BITS = sasm_pkg::ADC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sasm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sasm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ADC_BITS-1:0]                adc_value,
    input  logic [1:0]                         digit_select,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [6:0]                         segments,
    output logic [3:0]                         digit_enable,
    output logic                               point_one,
    output logic                               point_two
);

    localparam int VW = ADC_BITS + 3;

    logic [sasm_pkg::MODE_W-1:0]  show_mode_reg;
    logic [sasm_pkg::TICKS_W-1:0] ticks_reg;
    logic [sasm_pkg::TICKS_W-1:0] remaining_reg;
    logic [sasm_pkg::TICKS_W-1:0] remaining_next;

    logic                a_valid_reg;
    logic [ADC_BITS-1:0] a_sample_reg;
    logic [1:0]          a_sel_reg;
    logic                a_count_reg;

    logic                b_valid_reg;
    logic [VW-1:0]       b_value_reg;
    logic [1:0]          b_sel_reg;
    logic                b_count_reg;

    logic                out_valid_reg;
    logic [6:0]          segments_reg;
    logic [3:0]          enable_reg;
    logic                point_one_reg;
    logic                point_two_reg;

    logic cfg_write;
    logic in_take;
    logic c_free;
    logic b_free;
    logic b_move;
    logic a_move;

    logic [VW-1:0]        scaled_value;
    sasm_pkg::digit_set_t digits;
    logic [3:0]           mode_hi;
    logic [4:0]           glyph_idx;
    logic [2:0]           place_match_sel;
    logic                 place_hit;
    logic [6:0]           segments_next;
    logic                 point_one_next;
    logic                 point_two_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // pipeline flow control
    assign c_free   = !out_valid_reg || out_ready;
    assign b_move   = b_valid_reg && c_free;
    assign b_free   = !b_valid_reg || c_free;
    assign a_move   = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_mode_reg <= '0;
            ticks_reg     <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == sasm_pkg::REG_SHOW_MODE)
                show_mode_reg <= cfg_data[sasm_pkg::MODE_W-1:0];
            else if (cfg_index == sasm_pkg::REG_MODE_TICKS)
                ticks_reg <= cfg_data[sasm_pkg::TICKS_W-1:0];
        end
    end

    // countdown reloads on any listed register write, drops once per request
    always_comb
    begin
        remaining_next = remaining_reg;
        if (cfg_write && cfg_index == sasm_pkg::REG_SHOW_MODE)
            remaining_next = ticks_reg;
        else if (cfg_write && cfg_index == sasm_pkg::REG_MODE_TICKS)
            remaining_next = cfg_data[sasm_pkg::TICKS_W-1:0];
        else if (in_take && remaining_reg != '0)
            remaining_next = remaining_reg - sasm_pkg::TICKS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remaining_reg <= '0;
        else
            remaining_reg <= remaining_next;
    end

    // stage a: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (in_ready)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_sample_reg <= adc_value;
            a_sel_reg    <= digit_select;
            a_count_reg  <= (remaining_reg != '0);
        end
    end

    sasm_scale #(
        .ADC_BITS (ADC_BITS)
    ) u_scale (
        .sample    (a_sample_reg),
        .scale_sel (show_mode_reg[1:0]),
        .round_en  (show_mode_reg[2]),
        .value     (scaled_value)
    );

    // stage b: scaled value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (b_free)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_move)
        begin
            b_value_reg <= scaled_value;
            b_sel_reg   <= a_sel_reg;
            b_count_reg <= a_count_reg;
        end
    end

    sasm_digits #(
        .VALUE_W (VW)
    ) u_digits (
        .value  (b_value_reg),
        .digits (digits)
    );

    // high mode nibble shown mod 10
    assign mode_hi = (show_mode_reg[7:4] >= 4'd10) ? (show_mode_reg[7:4] - 4'd10)
                                                   : show_mode_reg[7:4];

    always_comb
    begin
        if (b_count_reg)
        begin
            case (b_sel_reg)
                sasm_pkg::DIGIT_HUNDREDS: glyph_idx = {1'b0, mode_hi};
                sasm_pkg::DIGIT_TENS:     glyph_idx = {1'b0, show_mode_reg[3:0]};
                default:                  glyph_idx = sasm_pkg::GLYPH_BLANK;
            endcase
        end
        else
        begin
            case (b_sel_reg)
                sasm_pkg::DIGIT_THOUSANDS: glyph_idx = {1'b0, digits.thousands};
                sasm_pkg::DIGIT_HUNDREDS:  glyph_idx = {1'b0, digits.hundreds};
                sasm_pkg::DIGIT_TENS:      glyph_idx = {1'b0, digits.tens};
                default:                   glyph_idx = {1'b0, digits.ones};
            endcase
        end
    end

    // point position 1..3 in mode bits 5:4 names thousands..tens, bit 6 picks the point
    assign place_match_sel = {1'b0, b_sel_reg} + 3'd1;
    assign place_hit = (show_mode_reg[5:4] != 2'd0) &&
                       ({1'b0, show_mode_reg[5:4]} == place_match_sel);
    assign point_one_next = b_count_reg || (place_hit && !show_mode_reg[6]);
    assign point_two_next = b_count_reg || (place_hit && show_mode_reg[6]);
    assign segments_next  = sasm_pkg::glyph_pattern(glyph_idx);

    // stage c: result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (c_free)
            out_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            segments_reg  <= segments_next;
            enable_reg    <= 4'b1000 >> b_sel_reg;
            point_one_reg <= point_one_next;
            point_two_reg <= point_two_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_enable = enable_reg;
    assign point_one    = point_one_reg;
    assign point_two    = point_two_reg;

    // countdown only moves on a register write or an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_write && !in_take) |=> (remaining_reg == $past(remaining_reg)))
        else $error("countdown changed without a write or request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_write && in_take && remaining_reg != '0) |=>
        (remaining_reg == $past(remaining_reg) - sasm_pkg::TICKS_W'(1)))
        else $error("countdown did not drop by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(enable_reg))
        else $error("digit enable not one-hot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (b_move && b_count_reg) |=> (point_one_reg && point_two_reg))
        else $error("points not lit during mode display");

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> (a_valid_reg && $stable(a_sample_reg)))
        else $error("stalled input stage lost its request");

endmodule
